/* rtl/c8exec_pkg.sv */
`timescale 1ns / 1ps

package c8exec_pkg;

	localparam int ADDR_W          = 12;
	localparam int MEM_BYTES       = 4096;
	localparam int SCREEN_WIDTH    = 64;
	localparam int SCREEN_HEIGHT   = 32;
	localparam int ROW_W           = 5;
	localparam int STACK_DEPTH_DEF = 16;
	localparam int CFG_ADDR_W      = 3;
	localparam int CFG_DATA_W      = 32;

	localparam logic [ADDR_W-1:0] FONT_BASE_RST     = 12'd80;
	localparam logic [ADDR_W-1:0] START_ADDRESS_RST = 12'd512;

	// Configuration register indexes, taken from byte address bit 2.
	localparam logic REG_FONT_BASE     = 1'b0;
	localparam logic REG_START_ADDRESS = 1'b1;

	// Item operations.
	localparam logic [2:0] OP_EXECUTE   = 3'd0;
	localparam logic [2:0] OP_TICK      = 3'd1;
	localparam logic [2:0] OP_MEM_WRITE = 3'd2;
	localparam logic [2:0] OP_MEM_READ  = 3'd3;
	localparam logic [2:0] OP_ROW_READ  = 3'd4;
	localparam logic [2:0] OP_REG_READ  = 3'd5;

	// Instruction groups (top nibble).
	localparam logic [3:0] GRP_SYS   = 4'h0;
	localparam logic [3:0] GRP_JUMP  = 4'h1;
	localparam logic [3:0] GRP_CALL  = 4'h2;
	localparam logic [3:0] GRP_SEQK  = 4'h3;
	localparam logic [3:0] GRP_SNEK  = 4'h4;
	localparam logic [3:0] GRP_SEQV  = 4'h5;
	localparam logic [3:0] GRP_LDK   = 4'h6;
	localparam logic [3:0] GRP_ADDK  = 4'h7;
	localparam logic [3:0] GRP_ALU   = 4'h8;
	localparam logic [3:0] GRP_SNEV  = 4'h9;
	localparam logic [3:0] GRP_LDI   = 4'hA;
	localparam logic [3:0] GRP_JMPV0 = 4'hB;
	localparam logic [3:0] GRP_RAND  = 4'hC;
	localparam logic [3:0] GRP_DRAW  = 4'hD;
	localparam logic [3:0] GRP_KEY   = 4'hE;
	localparam logic [3:0] GRP_MISC  = 4'hF;

	localparam logic [15:0] SYS_CLS = 16'h00E0;
	localparam logic [15:0] SYS_RET = 16'h00EE;

	localparam logic [3:0] ALU_MOV = 4'h0;
	localparam logic [3:0] ALU_OR  = 4'h1;
	localparam logic [3:0] ALU_AND = 4'h2;
	localparam logic [3:0] ALU_XOR = 4'h3;
	localparam logic [3:0] ALU_ADD = 4'h4;
	localparam logic [3:0] ALU_SUB = 4'h5;
	localparam logic [3:0] ALU_SHR = 4'h6;
	localparam logic [3:0] ALU_SBN = 4'h7;
	localparam logic [3:0] ALU_SHL = 4'hE;

	localparam logic [7:0] KEY_SKIP_DOWN = 8'h9E;
	localparam logic [7:0] KEY_SKIP_UP   = 8'hA1;

	localparam logic [7:0] MISC_GET_DELAY = 8'h07;
	localparam logic [7:0] MISC_WAIT_KEY  = 8'h0A;
	localparam logic [7:0] MISC_SET_DELAY = 8'h15;
	localparam logic [7:0] MISC_SET_SOUND = 8'h18;
	localparam logic [7:0] MISC_ADD_I     = 8'h1E;
	localparam logic [7:0] MISC_FONT      = 8'h29;
	localparam logic [7:0] MISC_BCD       = 8'h33;
	localparam logic [7:0] MISC_STORE     = 8'h55;
	localparam logic [7:0] MISC_LOAD      = 8'h65;

	typedef struct packed {
		logic [2:0]  op;
		logic [15:0] instruction;
		logic [7:0]  random_byte;
		logic [15:0] keys_down;
		logic [11:0] address;
		logic [7:0]  write_byte;
	} item_t;

	typedef struct packed {
		logic [11:0] next_pc;
		logic [11:0] read_value;
		logic [63:0] screen_row;
		logic        waiting_key;
		logic        sound_on;
		logic        stack_fault;
	} result_t;

	typedef struct packed {
		logic capture;
		logic rd_x;
		logic rd_y;
		logic rd_0;
		logic exec;
		logic loop_rd;
		logic loop_wr;
		logic fin;
		logic load_result;
	} cmd_t;

	typedef struct packed {
		logic loop_req;
		logic loop_last;
	} status_t;

	typedef struct packed {
		logic              font_we;
		logic              start_we;
		logic [ADDR_W-1:0] data;
	} cfg_wr_t;

	// Hundreds, tens and ones of a byte, one nibble each.
	function automatic logic [11:0] bcd_digits(input logic [7:0] v);
		logic [1:0] h;
		logic [7:0] r;
		logic [3:0] t;
		logic [7:0] o;
		h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
		r = v - ((h == 2'd2) ? 8'd200 : ((h == 2'd1) ? 8'd100 : 8'd0));
		t = 4'd0;
		for (int i = 1; i < 10; i++) begin
			if (r >= 8'(10 * i)) begin
				t = 4'(i);
			end
		end
		o = r - ({4'b0000, t} << 3) - ({4'b0000, t} << 1);
		return {2'b00, h, t, o[3:0]};
	endfunction

endpackage

/* rtl/c8exec_ctrl.sv */
`timescale 1ns / 1ps

module c8exec_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	output logic                 result_valid,
	input  logic                 result_stall,
	input  c8exec_pkg::status_t  status,
	output c8exec_pkg::cmd_t     cmd
);

	typedef enum logic [8:0] {
		ST_IDLE    = 9'b000000001,
		ST_RD_X    = 9'b000000010,
		ST_RD_Y    = 9'b000000100,
		ST_RD_0    = 9'b000001000,
		ST_EXEC    = 9'b000010000,
		ST_LOOP_RD = 9'b000100000,
		ST_LOOP_WR = 9'b001000000,
		ST_FIN     = 9'b010000000,
		ST_DONE    = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   result_valid_q;
	logic   load_ok;

	assign load_ok      = !result_valid_q || !result_stall;
	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_RD_X;
				end
			end
			ST_RD_X: begin
				cmd.rd_x = 1'b1;
				state_d  = ST_RD_Y;
			end
			ST_RD_Y: begin
				cmd.rd_y = 1'b1;
				state_d  = ST_RD_0;
			end
			ST_RD_0: begin
				cmd.rd_0 = 1'b1;
				state_d  = ST_EXEC;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = status.loop_req ? ST_LOOP_RD : ST_FIN;
			end
			ST_LOOP_RD: begin
				cmd.loop_rd = 1'b1;
				state_d     = ST_LOOP_WR;
			end
			ST_LOOP_WR: begin
				cmd.loop_wr = 1'b1;
				state_d     = status.loop_last ? ST_FIN : ST_LOOP_RD;
			end
			ST_FIN: begin
				cmd.fin = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (load_ok) begin
					cmd.load_result = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_result) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/c8exec_datapath.sv */
`timescale 1ns / 1ps

module c8exec_datapath #(
	parameter int STACK_DEPTH = c8exec_pkg::STACK_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  c8exec_pkg::item_t     item,
	input  c8exec_pkg::cmd_t      cmd,
	input  c8exec_pkg::cfg_wr_t   cfg,
	output c8exec_pkg::status_t   status,
	output c8exec_pkg::result_t   result,
	output logic [11:0]           font_value,
	output logic [11:0]           start_value
);

	localparam int SL_W   = $clog2(STACK_DEPTH + 1);
	localparam int SIDX_W = $clog2(STACK_DEPTH);

	c8exec_pkg::item_t   item_q;
	c8exec_pkg::result_t result_q;

	// Architectural registers.
	logic [11:0]     idx_q, idx_d;
	logic [11:0]     pc_q, pc_d;
	logic [SL_W-1:0] sl_q, sl_d;
	logic [7:0]      delay_q, delay_d;
	logic [7:0]      sound_q, sound_d;
	logic [11:0]     font_q, start_q;

	// Per-item working registers.
	logic [7:0]  vx_q, vy_q;
	logic [4:0]  k_q;
	logic        flag_q, flag_d;
	logic        vf_pend_q, vf_pend_d;
	logic [11:0] res_rv_q, res_rv_d;
	logic [63:0] res_row_q, res_row_d;
	logic        res_wait_q, res_wait_d;
	logic        res_fault_q, res_fault_d;

	// Register file, with valid bits standing in for the reset value of zero.
	logic [7:0]  vreg_mem [16];
	logic [15:0] vreg_vld_q;
	logic [7:0]  vreg_rd_q;
	logic        vreg_rd_vld_q;
	logic [3:0]  vreg_ra, vreg_wa;
	logic [7:0]  vreg_wd, vrd;
	logic        vreg_we;

	logic [7:0]  mem [c8exec_pkg::MEM_BYTES];
	logic [7:0]  mem_rd_q;
	logic [11:0] mem_ra, mem_wa;
	logic [7:0]  mem_wd;
	logic        mem_we;

	logic [63:0]                    frame_mem [c8exec_pkg::SCREEN_HEIGHT];
	logic [c8exec_pkg::SCREEN_HEIGHT-1:0] frame_vld_q;
	logic [63:0]                    frame_rd_q;
	logic                           frame_rd_vld_q;
	logic [4:0]                     frame_ra, frame_wa;
	logic [63:0]                    frame_wd;
	logic                           frame_we, frame_clear;

	logic [11:0] stack_mem [STACK_DEPTH];
	logic [11:0] stack_rd_q;
	logic [SIDX_W-1:0] stack_ra;
	logic [11:0] stack_wd;
	logic        stack_we;

	// Instruction fields.
	logic [3:0]  grp, fx, fy, fn;
	logic [7:0]  kk;
	logic [11:0] nnn;
	logic        is_exec, is_draw, is_bcd, is_store, is_load;
	logic [4:0]  loop_cnt;

	logic [11:0] pc_inc, pc_skip, loop_addr;
	logic [8:0]  sum9;
	logic        key_hit, key_any;
	logic [3:0]  key_num;
	logic [11:0] digits;
	logic [63:0] sprite_mask, row_old;

	function automatic logic [63:0] rotr_sprite(input logic [7:0] b, input logic [5:0] s);
		logic [127:0] d;
		d = {b, 56'b0, b, 56'b0} >> s;
		return d[63:0];
	endfunction

	assign grp = item_q.instruction[15:12];
	assign fx  = item_q.instruction[11:8];
	assign fy  = item_q.instruction[7:4];
	assign fn  = item_q.instruction[3:0];
	assign kk  = item_q.instruction[7:0];
	assign nnn = item_q.instruction[11:0];

	assign is_exec  = (item_q.op == c8exec_pkg::OP_EXECUTE);
	assign is_draw  = is_exec && (grp == c8exec_pkg::GRP_DRAW);
	assign is_bcd   = is_exec && (grp == c8exec_pkg::GRP_MISC) && (kk == c8exec_pkg::MISC_BCD);
	assign is_store = is_exec && (grp == c8exec_pkg::GRP_MISC) && (kk == c8exec_pkg::MISC_STORE);
	assign is_load  = is_exec && (grp == c8exec_pkg::GRP_MISC) && (kk == c8exec_pkg::MISC_LOAD);

	always_comb begin
		if (is_draw) begin
			loop_cnt = {1'b0, fn};
		end else if (is_bcd) begin
			loop_cnt = 5'd3;
		end else begin
			loop_cnt = {1'b0, fx} + 5'd1;
		end
	end

	assign status.loop_req  = (is_draw && (fn != 4'h0)) || is_bcd || is_store || is_load;
	assign status.loop_last = ((k_q + 5'd1) == loop_cnt);

	assign vrd       = vreg_rd_vld_q ? vreg_rd_q : 8'h00;
	assign pc_inc    = pc_q + 12'd2;
	assign pc_skip   = pc_q + 12'd4;
	assign loop_addr = idx_q + {7'b0, k_q};
	assign sum9      = {1'b0, vx_q} + {1'b0, vy_q};
	assign key_hit   = item_q.keys_down[vx_q[3:0]];
	assign key_any   = |item_q.keys_down;
	assign digits    = c8exec_pkg::bcd_digits(vx_q);
	assign sprite_mask = rotr_sprite(mem_rd_q, vx_q[5:0]);
	assign row_old   = frame_rd_vld_q ? frame_rd_q : 64'h0;

	always_comb begin
		key_num = 4'h0;
		for (int i = 0; i < 16; i++) begin
			if (item_q.keys_down[i]) begin
				key_num = 4'(i);
			end
		end
	end

	// Read addresses of the storage arrays.
	always_comb begin
		if (cmd.loop_rd) begin
			vreg_ra = k_q[3:0];
		end else if (cmd.rd_y) begin
			vreg_ra = fy;
		end else if (cmd.rd_0) begin
			vreg_ra = 4'h0;
		end else if (item_q.op == c8exec_pkg::OP_REG_READ) begin
			vreg_ra = item_q.address[3:0];
		end else begin
			vreg_ra = fx;
		end
		mem_ra   = cmd.loop_rd ? loop_addr : item_q.address;
		frame_ra = cmd.loop_rd ? (vy_q[4:0] + k_q) : item_q.address[4:0];
		stack_ra = SIDX_W'(sl_q - SL_W'(1));
	end

	// Next state of every register and the write ports.
	always_comb begin
		idx_d       = idx_q;
		pc_d        = pc_q;
		sl_d        = sl_q;
		delay_d     = delay_q;
		sound_d     = sound_q;
		flag_d      = flag_q;
		vf_pend_d   = vf_pend_q;
		res_rv_d    = res_rv_q;
		res_row_d   = res_row_q;
		res_wait_d  = res_wait_q;
		res_fault_d = res_fault_q;
		vreg_we     = 1'b0;
		vreg_wa     = fx;
		vreg_wd     = 8'h00;
		mem_we      = 1'b0;
		mem_wa      = loop_addr;
		mem_wd      = 8'h00;
		frame_we    = 1'b0;
		frame_wa    = vy_q[4:0] + k_q;
		frame_wd    = row_old ^ sprite_mask;
		frame_clear = 1'b0;
		stack_we    = 1'b0;
		stack_wd    = pc_inc;

		if (cmd.exec) begin
			res_rv_d    = 12'h000;
			res_row_d   = 64'h0;
			res_wait_d  = 1'b0;
			res_fault_d = 1'b0;
			flag_d      = 1'b0;
			vf_pend_d   = 1'b0;
			case (item_q.op)
				c8exec_pkg::OP_EXECUTE: begin
					pc_d = pc_inc;
					case (grp)
						c8exec_pkg::GRP_SYS: begin
							if (item_q.instruction == c8exec_pkg::SYS_CLS) begin
								frame_clear = 1'b1;
							end else if (item_q.instruction == c8exec_pkg::SYS_RET) begin
								if (sl_q == '0) begin
									pc_d        = 12'h000;
									res_fault_d = 1'b1;
								end else begin
									sl_d = sl_q - SL_W'(1);
									pc_d = stack_rd_q;
								end
							end
						end
						c8exec_pkg::GRP_JUMP: pc_d = nnn;
						c8exec_pkg::GRP_CALL: begin
							if (sl_q >= SL_W'(STACK_DEPTH)) begin
								res_fault_d = 1'b1;
							end else begin
								stack_we = 1'b1;
								sl_d     = sl_q + SL_W'(1);
								pc_d     = nnn;
							end
						end
						c8exec_pkg::GRP_SEQK: if (vx_q == kk) pc_d = pc_skip;
						c8exec_pkg::GRP_SNEK: if (vx_q != kk) pc_d = pc_skip;
						c8exec_pkg::GRP_SEQV: if (fn == 4'h0 && vx_q == vy_q) pc_d = pc_skip;
						c8exec_pkg::GRP_SNEV: if (fn == 4'h0 && vx_q != vy_q) pc_d = pc_skip;
						c8exec_pkg::GRP_LDK: begin
							vreg_we = 1'b1;
							vreg_wd = kk;
						end
						c8exec_pkg::GRP_ADDK: begin
							vreg_we = 1'b1;
							vreg_wd = vx_q + kk;
						end
						c8exec_pkg::GRP_ALU: begin
							case (fn)
								c8exec_pkg::ALU_MOV: begin
									vreg_we = 1'b1;
									vreg_wd = vy_q;
								end
								c8exec_pkg::ALU_OR: begin
									vreg_we = 1'b1;
									vreg_wd = vx_q | vy_q;
								end
								c8exec_pkg::ALU_AND: begin
									vreg_we = 1'b1;
									vreg_wd = vx_q & vy_q;
								end
								c8exec_pkg::ALU_XOR: begin
									vreg_we = 1'b1;
									vreg_wd = vx_q ^ vy_q;
								end
								c8exec_pkg::ALU_ADD: begin
									vreg_we   = 1'b1;
									vreg_wd   = sum9[7:0];
									flag_d    = sum9[8];
									vf_pend_d = (fx != 4'hF);
								end
								c8exec_pkg::ALU_SUB: begin
									vreg_we   = 1'b1;
									vreg_wd   = vx_q - vy_q;
									flag_d    = (vx_q > vy_q);
									vf_pend_d = (fx != 4'hF);
								end
								c8exec_pkg::ALU_SHR: begin
									vreg_we   = 1'b1;
									vreg_wd   = {1'b0, vx_q[7:1]};
									flag_d    = vx_q[0];
									vf_pend_d = (fx != 4'hF);
								end
								c8exec_pkg::ALU_SBN: begin
									vreg_we   = 1'b1;
									vreg_wd   = vy_q - vx_q;
									flag_d    = (vy_q > vx_q);
									vf_pend_d = (fx != 4'hF);
								end
								c8exec_pkg::ALU_SHL: begin
									vreg_we   = 1'b1;
									vreg_wd   = {vx_q[6:0], 1'b0};
									flag_d    = vx_q[7];
									vf_pend_d = (fx != 4'hF);
								end
								default: ;
							endcase
						end
						c8exec_pkg::GRP_LDI:   idx_d = nnn;
						c8exec_pkg::GRP_JMPV0: pc_d  = nnn + {4'h0, vrd};
						c8exec_pkg::GRP_RAND: begin
							vreg_we = 1'b1;
							vreg_wd = item_q.random_byte & kk;
						end
						c8exec_pkg::GRP_DRAW: begin
							// VF starts clear; the row loop gathers collisions.
							vf_pend_d = 1'b1;
						end
						c8exec_pkg::GRP_KEY: begin
							if (kk == c8exec_pkg::KEY_SKIP_DOWN && key_hit) begin
								pc_d = pc_skip;
							end else if (kk == c8exec_pkg::KEY_SKIP_UP && !key_hit) begin
								pc_d = pc_skip;
							end
						end
						c8exec_pkg::GRP_MISC: begin
							case (kk)
								c8exec_pkg::MISC_GET_DELAY: begin
									vreg_we = 1'b1;
									vreg_wd = delay_q;
								end
								c8exec_pkg::MISC_WAIT_KEY: begin
									if (key_any) begin
										vreg_we = 1'b1;
										vreg_wd = {4'h0, key_num};
									end else begin
										pc_d       = pc_q;
										res_wait_d = 1'b1;
									end
								end
								c8exec_pkg::MISC_SET_DELAY: delay_d = vx_q;
								c8exec_pkg::MISC_SET_SOUND: sound_d = vx_q;
								c8exec_pkg::MISC_ADD_I:     idx_d = idx_q + {4'h0, vx_q};
								c8exec_pkg::MISC_FONT: begin
									idx_d = font_q + {4'h0, vx_q} + {2'b00, vx_q, 2'b00};
								end
								default: ;
							endcase
						end
						default: ;
					endcase
				end
				c8exec_pkg::OP_TICK: begin
					if (delay_q != 8'h00) delay_d = delay_q - 8'd1;
					if (sound_q != 8'h00) sound_d = sound_q - 8'd1;
				end
				c8exec_pkg::OP_MEM_WRITE: begin
					mem_we = 1'b1;
					mem_wa = item_q.address;
					mem_wd = item_q.write_byte;
				end
				c8exec_pkg::OP_MEM_READ: res_rv_d = {4'h0, mem_rd_q};
				c8exec_pkg::OP_ROW_READ: begin
					if (item_q.address[11:5] == 7'd0) begin
						res_row_d = row_old;
					end
				end
				c8exec_pkg::OP_REG_READ: begin
					if (item_q.address[11:4] == 8'd0) begin
						res_rv_d = {4'h0, vx_q};
					end else if (item_q.address == 12'd16) begin
						res_rv_d = idx_q;
					end
				end
				default: ;
			endcase
		end

		if (cmd.loop_wr) begin
			if (is_draw) begin
				frame_we = 1'b1;
				if ((row_old & sprite_mask) != 64'h0) begin
					flag_d = 1'b1;
				end
			end else if (is_bcd) begin
				mem_we = 1'b1;
				case (k_q[1:0])
					2'd0:    mem_wd = {4'h0, digits[11:8]};
					2'd1:    mem_wd = {4'h0, digits[7:4]};
					default: mem_wd = {4'h0, digits[3:0]};
				endcase
			end else if (is_store) begin
				mem_we = 1'b1;
				mem_wd = vrd;
			end else begin
				vreg_we = 1'b1;
				vreg_wa = k_q[3:0];
				vreg_wd = mem_rd_q;
			end
		end

		if (cmd.fin && vf_pend_q) begin
			vreg_we   = 1'b1;
			vreg_wa   = 4'hF;
			vreg_wd   = {7'b0, flag_q};
			vf_pend_d = 1'b0;
		end

		if (cfg.start_we) begin
			pc_d = cfg.data;
		end
	end

	// Storage arrays.
	always_ff @(posedge clk) begin
		vreg_rd_q  <= vreg_mem[vreg_ra];
		mem_rd_q   <= mem[mem_ra];
		frame_rd_q <= frame_mem[frame_ra];
		stack_rd_q <= stack_mem[stack_ra];
		if (vreg_we) begin
			vreg_mem[vreg_wa] <= vreg_wd;
		end
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (frame_we) begin
			frame_mem[frame_wa] <= frame_wd;
		end
		if (stack_we) begin
			stack_mem[sl_q[SIDX_W-1:0]] <= stack_wd;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
		end
		if (cmd.rd_y) begin
			vx_q <= vrd;
		end
		if (cmd.rd_0) begin
			vy_q <= vrd;
		end
		if (cmd.load_result) begin
			result_q.next_pc     <= pc_q;
			result_q.read_value  <= res_rv_q;
			result_q.screen_row  <= res_row_q;
			result_q.waiting_key <= res_wait_q;
			result_q.sound_on    <= (sound_q != 8'h00);
			result_q.stack_fault <= res_fault_q;
		end
		res_rv_q    <= res_rv_d;
		res_row_q   <= res_row_d;
		res_wait_q  <= res_wait_d;
		res_fault_q <= res_fault_d;
	end

	// Control and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q          <= 12'h000;
			pc_q           <= c8exec_pkg::START_ADDRESS_RST;
			sl_q           <= '0;
			delay_q        <= 8'h00;
			sound_q        <= 8'h00;
			font_q         <= c8exec_pkg::FONT_BASE_RST;
			start_q        <= c8exec_pkg::START_ADDRESS_RST;
			k_q            <= 5'd0;
			flag_q         <= 1'b0;
			vf_pend_q      <= 1'b0;
			vreg_vld_q     <= '0;
			vreg_rd_vld_q  <= 1'b0;
			frame_vld_q    <= '0;
			frame_rd_vld_q <= 1'b0;
		end else begin
			idx_q          <= idx_d;
			pc_q           <= pc_d;
			sl_q           <= sl_d;
			delay_q        <= delay_d;
			sound_q        <= sound_d;
			flag_q         <= flag_d;
			vf_pend_q      <= vf_pend_d;
			vreg_rd_vld_q  <= vreg_vld_q[vreg_ra];
			frame_rd_vld_q <= frame_vld_q[frame_ra];
			if (cfg.font_we) begin
				font_q <= cfg.data;
			end
			if (cfg.start_we) begin
				start_q <= cfg.data;
			end
			if (cmd.exec) begin
				k_q <= 5'd0;
			end else if (cmd.loop_wr) begin
				k_q <= k_q + 5'd1;
			end
			if (vreg_we) begin
				vreg_vld_q[vreg_wa] <= 1'b1;
			end
			if (frame_clear) begin
				frame_vld_q <= '0;
			end else if (frame_we) begin
				frame_vld_q[frame_wa] <= 1'b1;
			end
		end
	end

	assign result      = result_q;
	assign font_value  = font_q;
	assign start_value = start_q;

endmodule

/* rtl/chip8_instruction_execute.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// item      in         item_valid / item_stall   c8exec_pkg::item_t
// result    out        result_valid / result_stall  c8exec_pkg::result_t
// config    in         APB write, psel+penable   font_base @0, start_address @4
//
// One transaction is in flight at a time. An access op or simple instruction passes through
// the operand reads, execute, finish and done states before its result is loaded, and the
// next item is taken in the cycle after; sprite rows, digit stores and block moves add a
// loop read and a loop write per byte. Reset is asynchronous and active low; the screen and
// registers read zero through valid bits, main memory and the call stack are never cleared.
// item_stall is high until the result is loaded, which waits while a held result stalls.
module chip8_instruction_execute #(
	parameter int STACK_DEPTH = c8exec_pkg::STACK_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  c8exec_pkg::item_t                   item,
	output logic                                result_valid,
	input  logic                                result_stall,
	output c8exec_pkg::result_t                 result,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [c8exec_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [c8exec_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [c8exec_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                                pready
);

	c8exec_pkg::cmd_t    cmd;
	c8exec_pkg::status_t status;
	c8exec_pkg::cfg_wr_t cfg;
	logic [11:0]         font_value;
	logic [11:0]         start_value;
	logic                cfg_write;

	// The port never waits, so a write completes in its access cycle.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	// Register index comes from byte address bit 2; writing the start address
	// also reloads the program counter inside the datapath.
	assign cfg.font_we  = cfg_write && (paddr[2] == c8exec_pkg::REG_FONT_BASE);
	assign cfg.start_we = cfg_write && (paddr[2] == c8exec_pkg::REG_START_ADDRESS);
	assign cfg.data     = pwdata[11:0];

	assign prdata = {20'h00000,
		(paddr[2] == c8exec_pkg::REG_START_ADDRESS) ? start_value : font_value};

	// The controller sequences operand reads, the execute cycle, the per-byte
	// loops and the hand-off to the output register.
	c8exec_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	// The datapath holds all machine state, memories and the output register.
	c8exec_datapath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.cmd         (cmd),
		.cfg         (cfg),
		.status      (status),
		.result      (result),
		.font_value  (font_value),
		.start_value (start_value)
	);

endmodule
